### sv/refcounted_priority_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// refcounted priority tracker assertion macros
// shared concurrent check forms used by the tracker rtl
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PRIORITY_TRACKER_TOP_DEFINES_SVH
`define REFCOUNTED_PRIORITY_TRACKER_TOP_DEFINES_SVH

// same-cycle implication check, quiet during reset
`define RPT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpt: same-cycle check failed");

// next-cycle implication check, quiet during reset
`define RPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpt: next-cycle check failed");

`endif

### sv/rpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_pkg
// types and fixed constants of the refcounted priority tracker
// ----------------------------------------------------------------------------
package rpt_pkg;

  // fixed field widths
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LEVEL    = 1'd1;

  // reset values
  localparam logic               CONTROL_ENABLED_RST = 1'b1;
  localparam logic [LEVEL_W-1:0] NORMAL_LEVEL_RST    = 3'd1;
  localparam logic [LEVEL_W-1:0] ACTIVE_LEVEL_RST    = 3'd1;

  // request operations
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // configuration seen by the sequencer
  typedef struct packed {
    logic               control_enabled;
    logic [LEVEL_W-1:0] normal_level;
  } rpt_cfg_t;

  // one result word
  typedef struct packed {
    logic               priority_changed;
    logic [LEVEL_W-1:0] current_level;
    logic               count_fault;
  } rpt_result_t;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } rpt_state_e;

endpackage

### sv/rpt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_req_if
// request channel: valid/ready handshake with operation and level
// ----------------------------------------------------------------------------
interface rpt_req_if import rpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output operation, output level, input ready);
  modport sink   (input valid, input operation, input level, output ready);
endinterface

### sv/rpt_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_res_if
// result channel: valid/ready handshake with the tracker result fields
// ----------------------------------------------------------------------------
interface rpt_res_if import rpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               priority_changed;
  logic [LEVEL_W-1:0] current_level;
  logic               count_fault;

  modport source (output valid, output priority_changed, output current_level,
                  output count_fault, input ready);
  modport sink   (input valid, input priority_changed, input current_level,
                  input count_fault, output ready);
endinterface

### sv/rpt_cnt_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_cnt_bank
// per-level job counters with one read port and one write port
// ----------------------------------------------------------------------------
module rpt_cnt_bank #(
  parameter int NUM_LEVELS = 5,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W     = $clog2(NUM_LEVELS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      addr_i,
  input  logic [COUNT_BITS-1:0] wdata_i,
  output logic [COUNT_BITS-1:0] rdata_o
);

  logic [COUNT_BITS-1:0] cnt_q [NUM_LEVELS];

  // counters clear at reset, one entry written per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (we_i && (32'(addr_i) < NUM_LEVELS)) begin
      cnt_q[addr_i] <= wdata_i;
    end
  end

  // read at the sequencer address, unused codes read as zero
  assign rdata_o = (32'(addr_i) < NUM_LEVELS) ? cnt_q[addr_i] : '0;

endmodule

### sv/rpt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_seq
// request sequencer with the shared increment/decrement and compare unit
// ----------------------------------------------------------------------------
`include "refcounted_priority_tracker_top_defines.svh"

module rpt_seq import rpt_pkg::*; #(
  parameter int NUM_LEVELS = 5,
  parameter int COUNT_BITS = 16,
  localparam int IDX_W     = $clog2(NUM_LEVELS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpt_cfg_t              cfg_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic                  req_op_i,
  input  logic [LEVEL_W-1:0]    req_level_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output rpt_result_t           res_o,
  output logic                  cnt_we_o,
  output logic [IDX_W-1:0]      cnt_addr_o,
  output logic [COUNT_BITS-1:0] cnt_wdata_o,
  input  logic [COUNT_BITS-1:0] cnt_rdata_i
);

  rpt_state_e         state_q, state_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [LEVEL_W-1:0] active_q, active_d;
  logic               changed_q, changed_d;
  logic               fault_q, fault_d;
  logic               op_q;
  logic [LEVEL_W-1:0] level_q;

  logic [COUNT_BITS-1:0] step_val;
  logic [COUNT_BITS-1:0] sum;
  logic                  cnt_is_max;
  logic                  cnt_is_zero;
  logic                  sum_is_zero;
  logic                  scan_hit;

  // shared unit: step the counter and compare
  assign step_val    = (op_q == OP_PUT) ? '1 : COUNT_BITS'(1);
  assign sum         = cnt_rdata_i + step_val;
  assign cnt_is_max  = (cnt_rdata_i == '1);
  assign cnt_is_zero = (cnt_rdata_i == '0);
  assign sum_is_zero = (sum == '0);
  assign scan_hit    = (32'(ptr_q) == 32'(cfg_i.normal_level)) || !cnt_is_zero;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign cnt_addr_o  = ptr_q;
  assign cnt_wdata_o = sum;

  assign res_o.priority_changed = changed_q;
  assign res_o.current_level    = active_q;
  assign res_o.count_fault      = fault_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    active_d  = active_q;
    changed_d = changed_q;
    fault_d   = fault_q;
    cnt_we_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          changed_d = 1'b0;
          fault_d   = 1'b0;
          ptr_d     = IDX_W'(req_level_i);
          if (cfg_i.control_enabled && (32'(req_level_i) < NUM_LEVELS)) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_READ: begin
        state_d = S_DONE;
        if (op_q == OP_GET) begin
          if (cnt_is_max) begin
            fault_d = 1'b1;
          end else begin
            cnt_we_o = 1'b1;
            if (level_q > active_q) begin
              active_d  = level_q;
              changed_d = 1'b1;
            end
          end
        end else begin
          if (cnt_is_zero) begin
            fault_d = 1'b1;
          end else begin
            cnt_we_o = 1'b1;
            if (sum_is_zero && (level_q != cfg_i.normal_level) &&
                (active_q <= level_q)) begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // walk down from the released level, one level a cycle
        if (scan_hit) begin
          active_d  = LEVEL_W'(ptr_q);
          changed_d = 1'b1;
          state_d   = S_DONE;
        end else if (ptr_q == '0) begin
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_q - IDX_W'(1);
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      active_q  <= ACTIVE_LEVEL_RST;
      changed_q <= 1'b0;
      fault_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      active_q  <= active_d;
      changed_q <= changed_d;
      fault_q   <= fault_d;
    end
  end

  // request word capture
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      op_q    <= req_op_i;
      level_q <= req_level_i;
    end
  end

  // checks
  `RPT_ASSERT_IMPL(a_fault_excludes_change, clk_i, rst_ni, res_valid_o, !(res_o.count_fault && res_o.priority_changed))
  `RPT_ASSERT_IMPL(a_scan_at_or_below_level, clk_i, rst_ni, state_q == S_SCAN, 32'(ptr_q) <= 32'(level_q))
  `RPT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o)
  `RPT_ASSERT_IMPL(a_active_in_range, clk_i, rst_ni, 1'b1, 32'(active_q) < NUM_LEVELS)

endmodule

### sv/refcounted_priority_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_priority_tracker_top
// per-level job counting and priority tracking for one engine
// ----------------------------------------------------------------------------
// usage:
//   req_i carries one request word (operation get/put, level). res_o returns
//   exactly one result word per request: whether the priority changed, the
//   current level afterwards, and a counter fault (get at full or put at zero).
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write control_enabled (index 0) and
//   normal_level (index 1); write only while no request is in flight.
// timing:
//   a request is taken in S_IDLE, its counter is read and, unless it faults,
//   updated in S_READ, then a put that empties a level other than the normal
//   level, at or above the current level, scans downward one level a cycle
//   in S_SCAN. a request with control disabled or level out of range skips
//   to S_DONE. from S_DONE the result moves into the output register; no new
//   request is taken until it has moved there.
// reset and stall:
//   reset clears all counters, sets the current level and normal level to 1
//   and enables control. a result waiting on a stalled receiver sits in the
//   output register while the next request is already taken and worked on;
//   that one then holds in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module refcounted_priority_tracker_top import rpt_pkg::*; #(
  parameter int NUM_LEVELS = 5,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rpt_req_if.sink               req_i,
  rpt_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = $clog2(NUM_LEVELS);

  rpt_cfg_t              cfg_q;
  rpt_result_t           seq_res;
  logic                  seq_res_valid;
  logic                  seq_res_ready;
  rpt_result_t           out_q;
  logic                  out_valid_q;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_addr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_enabled <= CONTROL_ENABLED_RST;
      cfg_q.normal_level    <= NORMAL_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONTROL_ENABLED: cfg_q.control_enabled <= cfg_wdata_i[0];
        CFG_NORMAL_LEVEL:    cfg_q.normal_level    <= cfg_wdata_i[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpt_seq #(
    .NUM_LEVELS (NUM_LEVELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_op_i    (req_i.operation),
    .req_level_i (req_i.level),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .res_o       (seq_res),
    .cnt_we_o    (cnt_we),
    .cnt_addr_o  (cnt_addr),
    .cnt_wdata_o (cnt_wdata),
    .cnt_rdata_i (cnt_rdata)
  );

  rpt_cnt_bank #(
    .NUM_LEVELS (NUM_LEVELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cnt_we),
    .addr_i  (cnt_addr),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  // output register
  assign seq_res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_ready) begin
      out_valid_q <= seq_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_ready && seq_res_valid) begin
      out_q <= seq_res;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.priority_changed = out_q.priority_changed;
  assign res_o.current_level    = out_q.current_level;
  assign res_o.count_fault      = out_q.count_fault;

endmodule
